/* hdl/dnsx_pkg.sv */
// ---------------------------------------------------------------------------
// DNS answer address extractor package
// Shared types, codes and constants for the parser front, queue and back.
// ---------------------------------------------------------------------------
package dnsx_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    localparam logic [15:0] MATCH_TYPE_RESET = 16'd1;

    localparam logic [15:0] HDR_QD_HI   = 16'd4;
    localparam logic [15:0] HDR_QD_LO   = 16'd5;
    localparam logic [15:0] HDR_AN_HI   = 16'd6;
    localparam logic [15:0] HDR_AN_LO   = 16'd7;
    localparam logic [15:0] HDR_LAST    = 16'd11;
    localparam logic [15:0] QFIX_LAST   = 16'd3;
    localparam logic [15:0] AFIX_TYPE_HI = 16'd0;
    localparam logic [15:0] AFIX_TYPE_LO = 16'd1;
    localparam logic [15:0] AFIX_RDL_HI = 16'd8;
    localparam logic [15:0] AFIX_RDL_LO = 16'd9;
    localparam logic [15:0] ADDR_BYTES  = 16'd4;
    localparam logic [15:0] ADDR_LAST   = 16'd3;
    localparam logic [1:0]  PTR_MARK    = 2'b11;

    localparam logic KIND_ADDR  = 1'b0;
    localparam logic KIND_END   = 1'b1;
    localparam logic STAT_OK    = 1'b0;
    localparam logic STAT_EARLY = 1'b1;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_QNAME  = 3'd1,
        PH_QFIXED = 3'd2,
        PH_ANAME  = 3'd3,
        PH_AFIXED = 3'd4,
        PH_RDATA  = 3'd5,
        PH_DONE   = 3'd6
    } t_phase;

    typedef enum logic {
        BK_FIRST = 1'b0,
        BK_END   = 1'b1
    } t_back_state;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic        result_kind;
        logic [31:0] ipv4_address;
        logic [15:0] answer_index;
        logic        parse_status;
        logic        last_result;
    } t_out_item;

    typedef struct packed {
        logic        has_addr;
        logic [31:0] addr;
        logic [15:0] idx;
        logic        has_end;
        logic        status;
    } t_evt;

    function automatic t_phase f_section(input logic [15:0] qleft, input logic [15:0] aleft);
        t_phase ph;
        if (qleft != 16'd0) begin
            ph = PH_QNAME;
        end else if (aleft != 16'd0) begin
            ph = PH_ANAME;
        end else begin
            ph = PH_DONE;
        end
        return ph;
    endfunction

endpackage

/* hdl/dnsx_front.sv */
// ---------------------------------------------------------------------------
// DNS parser front
// Walks header, questions and answer records one byte per accepted cycle and
// classifies each byte into an address event and/or an end event.
// ---------------------------------------------------------------------------
module dnsx_front
    import dnsx_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_accept,
    input  t_in_item    i_item,
    output logic        o_push,
    output t_evt        o_evt
);

    logic [15:0] r_match;
    t_phase      r_phase, n_phase;
    logic [15:0] r_bcnt, n_bcnt;
    logic [15:0] r_qleft, n_qleft;
    logic [15:0] r_aleft, n_aleft;
    logic [5:0]  r_lleft, n_lleft;
    logic [15:0] r_rtype, n_rtype;
    logic [15:0] r_rdlen, n_rdlen;
    logic [31:0] r_acc, n_acc;
    logic [15:0] r_acnt, n_acnt;

    logic [7:0]  w_b;
    logic        w_hit;
    logic        w_fin;
    logic        w_sect;
    logic        w_name_done;
    logic        w_done;

    assign w_b = i_item.data_byte;

    always_comb begin
        n_phase     = r_phase;
        n_bcnt      = r_bcnt;
        n_qleft     = r_qleft;
        n_aleft     = r_aleft;
        n_lleft     = r_lleft;
        n_rtype     = r_rtype;
        n_rdlen     = r_rdlen;
        n_acc       = r_acc;
        n_acnt      = r_acnt;
        w_hit       = 1'b0;
        w_fin       = 1'b0;
        w_sect      = 1'b0;
        w_name_done = 1'b0;

        case (r_phase)
            PH_HEADER: begin
                if (r_bcnt == HDR_QD_HI) begin
                    n_qleft = {w_b, 8'h00};
                end else if (r_bcnt == HDR_QD_LO) begin
                    n_qleft = r_qleft | {8'h00, w_b};
                end else if (r_bcnt == HDR_AN_HI) begin
                    n_aleft = {w_b, 8'h00};
                end else if (r_bcnt == HDR_AN_LO) begin
                    n_aleft = r_aleft | {8'h00, w_b};
                end
                if (r_bcnt == HDR_LAST) begin
                    w_sect = 1'b1;
                end else begin
                    n_bcnt = r_bcnt + 16'd1;
                end
            end
            PH_QNAME, PH_ANAME: begin
                if (r_bcnt != 16'd0) begin
                    n_bcnt      = 16'd0;
                    w_name_done = 1'b1;
                end else if (r_lleft != 6'd0) begin
                    n_lleft = r_lleft - 6'd1;
                end else if (w_b[7:6] == PTR_MARK) begin
                    n_bcnt = 16'd1;
                end else begin
                    n_lleft     = w_b[5:0];
                    w_name_done = (w_b[5:0] == 6'd0);
                end
                if (w_name_done) begin
                    n_phase = (r_phase == PH_QNAME) ? PH_QFIXED : PH_AFIXED;
                    n_bcnt  = 16'd0;
                end
            end
            PH_QFIXED: begin
                if (r_bcnt == QFIX_LAST) begin
                    n_qleft = r_qleft - 16'd1;
                    w_sect  = 1'b1;
                end else begin
                    n_bcnt = r_bcnt + 16'd1;
                end
            end
            PH_AFIXED: begin
                if (r_bcnt == AFIX_TYPE_HI) begin
                    n_rtype = {w_b, 8'h00};
                end else if (r_bcnt == AFIX_TYPE_LO) begin
                    n_rtype = r_rtype | {8'h00, w_b};
                end else if (r_bcnt == AFIX_RDL_HI) begin
                    n_rdlen = {w_b, 8'h00};
                end else if (r_bcnt == AFIX_RDL_LO) begin
                    n_rdlen = r_rdlen | {8'h00, w_b};
                end
                if (r_bcnt == AFIX_RDL_LO) begin
                    n_bcnt = 16'd0;
                    n_acc  = 32'd0;
                    if (n_rdlen == 16'd0) begin
                        w_fin = 1'b1;
                    end else begin
                        n_phase = PH_RDATA;
                    end
                end else begin
                    n_bcnt = r_bcnt + 16'd1;
                end
            end
            PH_RDATA: begin
                if (r_bcnt < ADDR_BYTES) begin
                    n_acc = {r_acc[23:0], w_b};
                end
                w_hit = (r_bcnt == ADDR_LAST) && (r_rtype == r_match);
                if (({1'b0, r_bcnt} + 17'd1) >= {1'b0, r_rdlen}) begin
                    w_fin = 1'b1;
                end else begin
                    n_bcnt = r_bcnt + 16'd1;
                end
            end
            default: begin
            end
        endcase

        if (w_fin) begin
            n_acnt  = r_acnt + 16'd1;
            n_aleft = r_aleft - 16'd1;
            w_sect  = 1'b1;
        end
        if (w_sect) begin
            n_bcnt  = 16'd0;
            n_lleft = 6'd0;
            n_phase = f_section(n_qleft, n_aleft);
        end

        w_done = (n_phase >= PH_DONE);

        o_evt.has_addr = w_hit;
        o_evt.addr     = n_acc;
        o_evt.idx      = r_acnt;
        o_evt.has_end  = i_item.last_byte;
        o_evt.status   = w_done ? STAT_OK : STAT_EARLY;

        if (i_item.last_byte) begin
            n_phase = PH_HEADER;
            n_bcnt  = 16'd0;
            n_qleft = 16'd0;
            n_aleft = 16'd0;
            n_lleft = 6'd0;
            n_rtype = 16'd0;
            n_rdlen = 16'd0;
            n_acc   = 32'd0;
            n_acnt  = 16'd0;
        end
    end

    assign o_push = i_accept && (w_hit || i_item.last_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= MATCH_TYPE_RESET;
        end else if (i_cfg_wr_en) begin
            r_match <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_bcnt  <= 16'd0;
            r_qleft <= 16'd0;
            r_aleft <= 16'd0;
            r_lleft <= 6'd0;
            r_rtype <= 16'd0;
            r_rdlen <= 16'd0;
            r_acc   <= 32'd0;
            r_acnt  <= 16'd0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_bcnt  <= n_bcnt;
            r_qleft <= n_qleft;
            r_aleft <= n_aleft;
            r_lleft <= n_lleft;
            r_rtype <= n_rtype;
            r_rdlen <= n_rdlen;
            r_acc   <= n_acc;
            r_acnt  <= n_acnt;
        end
    end

    a_addr_from_rdata: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_evt.has_addr) |-> (r_phase == PH_RDATA && r_bcnt == ADDR_LAST))
        else $error("address event outside fourth rdata byte");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_item.last_byte) |=> (r_phase == PH_HEADER && r_bcnt == 16'd0))
        else $error("parser not cleared after last byte");

endmodule

/* hdl/dnsx_queue.sv */
// ---------------------------------------------------------------------------
// DNS event queue
// Short FIFO of classified events between the parser front and result back.
// ---------------------------------------------------------------------------
module dnsx_queue
    import dnsx_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_evt i_push_data,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_evt o_head
);

    t_evt           r_mem [QDEPTH];
    logic [QAW-1:0] r_wptr, r_rptr;
    logic [QCW-1:0] r_count, n_count;

    assign o_full  = (r_count == QCW'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rptr];

    always_comb begin
        n_count = r_count;
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + QCW'(1);
            2'b01:   n_count = r_count - QCW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + QAW'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + QAW'(1);
            end
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

endmodule

/* hdl/dnsx_back.sv */
// ---------------------------------------------------------------------------
// DNS result back
// Expands queued events into address and end results behind an output
// register.
// ---------------------------------------------------------------------------
module dnsx_back
    import dnsx_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_evt      i_q_head,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    t_back_state r_state, n_state;
    logic        r_valid, n_valid;
    t_out_item   r_item, n_item;
    logic        w_load;

    assign w_load = !r_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        if (w_load && i_q_valid) begin
            if (r_state == BK_FIRST && i_q_head.has_addr && i_q_head.has_end) begin
                n_state = BK_END;
            end else begin
                n_state = BK_FIRST;
            end
        end
    end

    always_comb begin
        o_pop   = 1'b0;
        n_valid = r_valid;
        n_item  = r_item;
        if (w_load) begin
            n_valid = i_q_valid;
            if (i_q_valid) begin
                if (r_state == BK_END || !i_q_head.has_addr) begin
                    n_item.result_kind  = KIND_END;
                    n_item.ipv4_address = 32'd0;
                    n_item.answer_index = 16'd0;
                    n_item.parse_status = i_q_head.status;
                    n_item.last_result  = 1'b1;
                    o_pop               = 1'b1;
                end else begin
                    n_item.result_kind  = KIND_ADDR;
                    n_item.ipv4_address = i_q_head.addr;
                    n_item.answer_index = i_q_head.idx;
                    n_item.parse_status = STAT_OK;
                    n_item.last_result  = !i_q_head.has_end;
                    o_pop               = !i_q_head.has_end;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_FIRST;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

    a_end_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_END) |-> (i_q_valid && i_q_head.has_end && i_q_head.has_addr))
        else $error("end result pending without queued event");

    a_pop_on_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> n_item.last_result)
        else $error("event popped before its final result");

endmodule

/* hdl/dns_answer_address_extractor_core.sv */
// ---------------------------------------------------------------------------
// DNS answer address extractor core
// Each result is registered in the 4-entry event queue, then in the output
// register. Throughput: one message byte per cycle while the queue is not
// full; the parser front does all state work in the accepting cycle. A last
// byte that also ends an address record yields two results from one event.
// Reset: synchronous active-low; parser returns to the header, match type to 1.
// ---------------------------------------------------------------------------
module dns_answer_address_extractor_core
    import dnsx_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item
);

    logic w_accept;
    logic w_push;
    t_evt w_evt;
    logic w_full;
    logic w_q_valid;
    t_evt w_q_head;
    logic w_pop;

    assign o_in_ready = !w_full;
    assign w_accept   = i_in_valid && !w_full;

    dnsx_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (w_accept),
        .i_item        (i_in_item),
        .o_push        (w_push),
        .o_evt         (w_evt)
    );

    dnsx_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_evt),
        .i_pop       (w_pop),
        .o_full      (w_full),
        .o_valid     (w_q_valid),
        .o_head      (w_q_head)
    );

    dnsx_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_head    (w_q_head),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
